// ===== src/mi3_pkg.sv =====
// Shared types, widths and tables for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Exact intermediate widths
  localparam int PROD_W = 2 * WORD_BITS;            // element product
  localparam int ADJ_W  = 2 * WORD_BITS + 1;        // adjugate element
  localparam int DET_W  = 3 * WORD_BITS + 3;        // determinant
  localparam int NUM_W  = ADJ_W + 2 * FRAC_BITS;    // rescaled numerator
  localparam int DIV_W  = DET_W + WORD_BITS - 1;    // divider datapath
  localparam int QBITS  = WORD_BITS - 1;            // quotient bits below saturation
  localparam int STEP_W = $clog2(QBITS);
  localparam int NELEM  = 9;
  localparam int ELEM_W = $clog2(NELEM);
  localparam int QDEPTH = 2;

  // Adjugate element k = m[a]*m[b] - m[c]*m[d]
  localparam int ADJ_TAB [NELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t m_00; word_t m_01; word_t m_02;
    word_t m_10; word_t m_11; word_t m_12;
    word_t m_20; word_t m_21; word_t m_22;
  } mat_t;

  typedef struct packed {
    word_t inv_00; word_t inv_01; word_t inv_02;
    word_t inv_10; word_t inv_11; word_t inv_12;
    word_t inv_20; word_t inv_21; word_t inv_22;
    logic  singular;
  } res_t;

  // One classified matrix: exact adjugate and determinant
  typedef struct packed {
    logic [NELEM-1:0][ADJ_W-1:0] adj;
    logic [DET_W-1:0]            det;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_ITER,
    B_DONE
  } back_state_t;

endpackage

// ===== src/mi3_if.sv =====
// Valid/ready channels for matrices in and inverses out.
interface mi3_mat_if;
  logic          valid;
  logic          ready;
  mi3_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mi3_res_if;
  logic          valid;
  logic          ready;
  mi3_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/mi3_front.sv =====
// Front pipeline: cofactors and determinant, five stages.
module mi3_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mi3_pkg::mat_t in_data,
  output logic          job_valid,
  input  logic          job_ready,
  output mi3_pkg::job_t job
);

  localparam int W  = mi3_pkg::WORD_BITS;
  localparam int PW = mi3_pkg::PROD_W;
  localparam int AW = mi3_pkg::ADJ_W;
  localparam int DW = mi3_pkg::DET_W;
  localparam int N  = mi3_pkg::NELEM;

  logic                 v1, v2, v3, v4;
  logic                 adv;
  mi3_pkg::word_t       m [N];
  logic signed [PW-1:0] p1 [N];
  logic signed [PW-1:0] p2 [N];
  mi3_pkg::word_t       r0_s1 [3];
  mi3_pkg::word_t       r0_s2 [3];
  logic signed [AW-1:0] adj_s2 [N];
  logic signed [AW-1:0] adj_s3 [N];
  logic signed [AW-1:0] adj_s4 [N];
  logic signed [AW-1:0] pl [3];
  logic signed [AW-1:0] ph [3];
  logic signed [DW-1:0] t [3];

  // whole pipe moves unless the last stage is held by a full queue
  assign adv      = !job_valid || job_ready;
  assign in_ready = adv;

  always_comb begin
    m[0] = in_data.m_00; m[1] = in_data.m_01; m[2] = in_data.m_02;
    m[3] = in_data.m_10; m[4] = in_data.m_11; m[5] = in_data.m_12;
    m[6] = in_data.m_20; m[7] = in_data.m_21; m[8] = in_data.m_22;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; job_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; job_valid <= v4;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: element products
      for (int k = 0; k < N; k++) begin
        p1[k] <= m[mi3_pkg::ADJ_TAB[k][0]] * m[mi3_pkg::ADJ_TAB[k][1]];
        p2[k] <= m[mi3_pkg::ADJ_TAB[k][2]] * m[mi3_pkg::ADJ_TAB[k][3]];
      end
      for (int j = 0; j < 3; j++) r0_s1[j] <= m[j];
      // stage 2: adjugate
      for (int k = 0; k < N; k++)
        adj_s2[k] <= {p1[k][PW-1], p1[k]} - {p2[k][PW-1], p2[k]};
      r0_s2 <= r0_s1;
      // stage 3: first-row partial products, adjugate split in two halves
      for (int j = 0; j < 3; j++) begin
        pl[j] <= r0_s2[j] * $signed({1'b0, adj_s2[3*j][W-1:0]});
        ph[j] <= r0_s2[j] * $signed(adj_s2[3*j][AW-1:W]);
      end
      adj_s3 <= adj_s2;
      // stage 4: rejoin halves
      for (int j = 0; j < 3; j++)
        t[j] <= ({{(DW-AW){ph[j][AW-1]}}, ph[j]} <<< W)
              + {{(DW-AW){pl[j][AW-1]}}, pl[j]};
      adj_s4 <= adj_s3;
      // stage 5: determinant
      job.det <= t[0] + t[1] + t[2];
      for (int k = 0; k < N; k++) job.adj[k] <= adj_s4[k];
    end
  end

endmodule

// ===== src/mi3_fifo.sv =====
// Short queue of classified items between front and back.
module mi3_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mi3_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mi3_pkg::job_t pop_data
);

  localparam int D  = mi3_pkg::QDEPTH;
  localparam int PB = $clog2(D);

  mi3_pkg::job_t   mem [D];
  logic [PB-1:0]   wp, rp;
  logic [PB:0]     cnt;
  logic            push, pop;

  assign push_ready = (cnt != (PB+1)'(D));
  assign pop_valid  = (cnt != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

endmodule

// ===== src/mi3_back.sv =====
// Back end: shared restoring divider, saturation and result register.
module mi3_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  mi3_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output mi3_pkg::res_t out_data
);

  localparam int W   = mi3_pkg::WORD_BITS;
  localparam int F   = mi3_pkg::FRAC_BITS;
  localparam int AW  = mi3_pkg::ADJ_W;
  localparam int DW  = mi3_pkg::DET_W;
  localparam int NW  = mi3_pkg::NUM_W;
  localparam int VW  = mi3_pkg::DIV_W;
  localparam int QB  = mi3_pkg::QBITS;
  localparam int SW  = mi3_pkg::STEP_W;
  localparam int N   = mi3_pkg::NELEM;
  localparam int EW  = mi3_pkg::ELEM_W;

  mi3_pkg::back_state_t state, state_next;
  mi3_pkg::job_t        cur;
  logic [DW-1:0]        dmag;
  logic                 dneg, dzero, neg;
  logic [EW-1:0]        k;
  logic [SW-1:0]        step;
  logic [VW-1:0]        rem, ds;
  logic [QB-1:0]        q, qn;
  logic [N-1:0][W-1:0]  res;

  logic signed [AW-1:0] adj_sel;
  logic [AW-1:0]        adj_mag;
  logic [VW-1:0]        num;
  logic                 sat, ge, last_elem, out_free;
  logic signed [DW-1:0] det_s;
  logic [W-1:0]         sat_val, q_val;

  always_comb begin
    adj_sel   = $signed(cur.adj[k]);
    adj_mag   = adj_sel[AW-1] ? AW'(-adj_sel) : adj_sel;
    num       = VW'({adj_mag, {(2*F){1'b0}}});
    sat       = (num >= {dmag, {(W-1){1'b0}}});
    ge        = (rem >= ds);
    qn        = q | (ge ? (QB'(1) << step) : '0);
    // clamp value for the element being loaded, sign from adjugate and determinant
    sat_val   = (adj_sel[AW-1] ^ dneg) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    q_val     = neg ? (W'(0) - {1'b0, qn}) : {1'b0, qn};
    det_s     = $signed(job.det);
    last_elem = (k == EW'(N-1));
    out_free  = !out_valid || out_ready;
    job_ready = (state == mi3_pkg::B_IDLE);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= mi3_pkg::B_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mi3_pkg::B_IDLE:
        if (job_valid)
          state_next = (job.det == '0) ? mi3_pkg::B_DONE : mi3_pkg::B_LOAD;
      mi3_pkg::B_LOAD: begin
        // sign of the quotient is set here from the element chosen by k
        if (!sat)           state_next = mi3_pkg::B_ITER;
        else if (last_elem) state_next = mi3_pkg::B_DONE;
      end
      mi3_pkg::B_ITER:
        if (step == '0) state_next = last_elem ? mi3_pkg::B_DONE : mi3_pkg::B_LOAD;
      mi3_pkg::B_DONE:
        if (out_free) state_next = mi3_pkg::B_IDLE;
      default: state_next = mi3_pkg::B_IDLE;
    endcase
  end

  // divider datapath
  always_ff @(posedge clk) begin
    unique case (state)
      mi3_pkg::B_IDLE:
        if (job_valid) begin
          cur   <= job;
          dmag  <= det_s[DW-1] ? DW'(-det_s) : job.det;
          dneg  <= det_s[DW-1];
          dzero <= (job.det == '0);
          k     <= '0;
        end
      mi3_pkg::B_LOAD: begin
        rem  <= num;
        ds   <= VW'({dmag, {(W-2){1'b0}}});
        step <= SW'(QB-1);
        q    <= '0;
        neg  <= adj_sel[AW-1] ^ dneg;
        if (sat) begin
          res[k] <= sat_val;
          if (!last_elem) k <= k + 1'b1;
        end
      end
      mi3_pkg::B_ITER: begin
        if (ge) rem <= rem - ds;
        ds   <= ds >> 1;
        q    <= qn;
        step <= step - 1'b1;
        if (step == '0) begin
          res[k] <= q_val;
          if (!last_elem) k <= k + 1'b1;
        end
      end
      mi3_pkg::B_DONE: ;
      default: ;
    endcase
  end

  // result register, free to fill again once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mi3_pkg::B_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mi3_pkg::B_DONE && out_free) begin
      out_data.inv_00   <= dzero ? '0 : res[0];
      out_data.inv_01   <= dzero ? '0 : res[1];
      out_data.inv_02   <= dzero ? '0 : res[2];
      out_data.inv_10   <= dzero ? '0 : res[3];
      out_data.inv_11   <= dzero ? '0 : res[4];
      out_data.inv_12   <= dzero ? '0 : res[5];
      out_data.inv_20   <= dzero ? '0 : res[6];
      out_data.inv_21   <= dzero ? '0 : res[7];
      out_data.inv_22   <= dzero ? '0 : res[8];
      out_data.singular <= dzero;
    end
  end

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.singular |-> out_data.inv_00 == '0 && out_data.inv_11 == '0
      && out_data.inv_22 == '0)
    else $error("singular result carries nonzero elements");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |=> state != mi3_pkg::B_IDLE)
    else $error("item taken but back end stayed idle");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == mi3_pkg::B_ITER |-> step <= SW'(QB-1))
    else $error("quotient bit counter out of range");

  a_elem_range: assert property (@(posedge clk) disable iff (rst)
    state == mi3_pkg::B_LOAD || state == mi3_pkg::B_ITER |-> k <= EW'(N-1))
    else $error("element index out of range");

endmodule

// ===== src/matrix_inverse_3x3.sv =====
// Top level of the 3x3 fixed-point matrix inverse.
// Path from the edge that takes a matrix to a valid result: 4 more front stages, queue write,
// back-end take, the divider for each of the nine elements in turn, result load.
// Throughput is set by the single shared restoring divider (one quotient bit per cycle), which
// takes no new matrix until the last result is loaded; the front takes an item each cycle
// until its two-entry queue is full. A singular matrix skips the divider.
// Reset (rst, synchronous): empties pipeline, queue and result register.
module matrix_inverse_3x3 (
  input logic       clk,
  input logic       rst,
  mi3_mat_if.sink   mat,
  mi3_res_if.source res
);

  logic          f_valid, f_ready, b_valid, b_ready;
  mi3_pkg::job_t f_job, b_job;

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat.valid),
    .in_ready  (mat.ready),
    .in_data   (mat.data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  mi3_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_job)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res.data)
  );

endmodule
